// ===== hdl/skms_pkg.sv =====
// shared types, codes and helpers for the stable k-way merge selector
// no dependencies; used by skms_ctrl, skms_dpath and the top level
`timescale 1ns / 1ps

package skms_pkg;

	// action codes carried in the input tuser
	localparam logic [1:0] ACT_WRITE   = 2'd0;
	localparam logic [1:0] ACT_LOAD    = 2'd1;
	localparam logic [1:0] ACT_EXHAUST = 2'd2;
	localparam logic [1:0] ACT_SELECT  = 2'd3;

	// artist, album, title, filename
	localparam int KEY_COUNT = 4;

	localparam logic [7:0] CHAR_UP_A = 8'h41;
	localparam logic [7:0] CHAR_UP_Z = 8'h5A;
	localparam logic [7:0] CHAR_LO_A = 8'h61;

	// stream widths
	localparam int IN_DATA_W  = 24;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 8;
	localparam int OUT_USER_W = 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_CMP,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic in_ready;
		logic scan_init;
		logic scan_step;
		logic take_best;
		logic cmp_init;
		logic byte_step;
		logic key_step;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_select;
		logic cand_loaded;
		logic cand_last;
		logic found;
		logic cand_less;
		logic cand_greater;
		logic str_end;
		logic idx_last;
		logic key_last;
		logic out_free;
	} status_t;

	// ascii upper case folded to lower case
	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
			r = c + (CHAR_LO_A - CHAR_UP_A);
		end
		return r;
	endfunction

endpackage

// ===== hdl/skms_ctrl.sv =====
// controller for the merge selector: scan of sources and byte-wise compare sequencing
// depends on skms_pkg; drives skms_dpath through cmd_t and reads status_t
`timescale 1ns / 1ps

module skms_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  skms_pkg::status_t sts,
	output skms_pkg::cmd_t    cmd
);

	skms_pkg::state_t state_q;
	skms_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skms_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			skms_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_select) begin
					cmd.scan_init = 1'b1;
					state_nxt     = skms_pkg::ST_SCAN;
				end
			end
			skms_pkg::ST_SCAN: begin
				if (sts.cand_loaded && sts.found) begin
					cmd.cmp_init = 1'b1;
					state_nxt    = skms_pkg::ST_READ;
				end else begin
					// first loaded head becomes best outright
					cmd.take_best = sts.cand_loaded;
					if (sts.cand_last) begin
						state_nxt = skms_pkg::ST_DONE;
					end else begin
						cmd.scan_step = 1'b1;
					end
				end
			end
			skms_pkg::ST_READ: begin
				state_nxt = skms_pkg::ST_CMP;
			end
			skms_pkg::ST_CMP: begin
				if (sts.cand_less || sts.cand_greater) begin
					cmd.take_best = sts.cand_less;
					if (sts.cand_last) begin
						state_nxt = skms_pkg::ST_DONE;
					end else begin
						cmd.scan_step = 1'b1;
						state_nxt     = skms_pkg::ST_SCAN;
					end
				end else if (sts.str_end || sts.idx_last) begin
					if (sts.key_last) begin
						// equal heads: the lower number stays best
						if (sts.cand_last) begin
							state_nxt = skms_pkg::ST_DONE;
						end else begin
							cmd.scan_step = 1'b1;
							state_nxt     = skms_pkg::ST_SCAN;
						end
					end else begin
						cmd.key_step = 1'b1;
						state_nxt    = skms_pkg::ST_READ;
					end
				end else begin
					cmd.byte_step = 1'b1;
					state_nxt     = skms_pkg::ST_READ;
				end
			end
			skms_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = skms_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = skms_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/skms_dpath.sv =====
// datapath for the merge selector: key store, loaded marks, counters, comparator, output word
// depends on skms_pkg; commanded by skms_ctrl
`timescale 1ns / 1ps

module skms_dpath #(
	parameter int MERGE_WAYS = 10,
	parameter int KEY_LENGTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  skms_pkg::cmd_t                      cmd,
	output skms_pkg::status_t                   sts,
	input  logic                                s_axis_tvalid,
	input  logic [skms_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input  logic [skms_pkg::IN_USER_W-1:0]      s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [skms_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic [skms_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

	localparam int SW    = $clog2(MERGE_WAYS);
	localparam int IW    = $clog2(KEY_LENGTH);
	localparam int KW    = $clog2(skms_pkg::KEY_COUNT);
	localparam int AW    = SW + KW + IW;
	localparam int DEPTH = MERGE_WAYS << (KW + IW);

	// input word fields
	logic [3:0] in_src;
	logic [1:0] in_key;
	logic [5:0] in_idx;
	logic [7:0] in_byte;
	logic       in_acc;
	logic       src_ok;
	logic       idx_ok;

	assign in_src  = s_axis_tdata[3:0];
	assign in_key  = s_axis_tdata[5:4];
	assign in_idx  = s_axis_tdata[11:6];
	assign in_byte = s_axis_tdata[19:12];
	assign in_acc  = s_axis_tvalid && cmd.in_ready;
	assign src_ok  = {28'd0, in_src} < 32'(MERGE_WAYS);
	assign idx_ok  = {26'd0, in_idx} < 32'(KEY_LENGTH);

	logic [7:0]            mem [DEPTH];
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         addr_a;
	logic [AW-1:0]         addr_b;
	logic [7:0]            rd_a_q;
	logic [7:0]            rd_b_q;

	logic [SW-1:0]         cand_q;
	logic [SW-1:0]         best_q;
	logic                  found_q;
	logic [KW-1:0]         key_q;
	logic [IW-1:0]         idx_q;
	logic [MERGE_WAYS-1:0] loaded_q;

	logic                  out_valid_q;
	logic [SW-1:0]         out_num_q;
	logic                  out_found_q;

	assign wr_addr = {SW'(in_src), KW'(in_key), IW'(in_idx)};
	assign addr_a  = {cand_q, key_q, idx_q};
	assign addr_b  = {best_q, key_q, idx_q};

	// key store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (in_acc && s_axis_tuser == skms_pkg::ACT_WRITE && src_ok && idx_ok) begin
			mem[wr_addr] <= in_byte;
		end
		rd_a_q <= mem[addr_a];
		rd_b_q <= mem[addr_b];
	end

	// scan and compare counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q  <= '0;
			best_q  <= '0;
			found_q <= 1'b0;
			key_q   <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.scan_init) begin
				cand_q  <= '0;
				best_q  <= '0;
				found_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				cand_q <= cand_q + 1'b1;
			end
			if (cmd.take_best) begin
				best_q  <= cand_q;
				found_q <= 1'b1;
			end
			if (cmd.cmp_init) begin
				key_q <= '0;
				idx_q <= '0;
			end
			if (cmd.key_step) begin
				key_q <= key_q + 1'b1;
				idx_q <= '0;
			end
			if (cmd.byte_step) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// loaded marks and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q    <= '0;
			out_valid_q <= 1'b0;
			out_num_q   <= '0;
			out_found_q <= 1'b0;
		end else begin
			if (in_acc && src_ok) begin
				if (s_axis_tuser == skms_pkg::ACT_LOAD) begin
					loaded_q[SW'(in_src)] <= 1'b1;
				end else if (s_axis_tuser == skms_pkg::ACT_EXHAUST) begin
					loaded_q[SW'(in_src)] <= 1'b0;
				end
			end
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				out_num_q   <= best_q;
				out_found_q <= found_q;
				if (found_q) begin
					loaded_q[best_q] <= 1'b0;
				end
			end
		end
	end

	// byte comparator, candidate against best
	logic [7:0] fa;
	logic [7:0] fb;
	logic       a_zero;
	logic       b_zero;

	assign fa     = skms_pkg::fold_case(rd_a_q);
	assign fb     = skms_pkg::fold_case(rd_b_q);
	assign a_zero = rd_a_q == 8'd0;
	assign b_zero = rd_b_q == 8'd0;

	always_comb begin
		sts              = '0;
		sts.in_select    = s_axis_tvalid && s_axis_tuser == skms_pkg::ACT_SELECT;
		sts.cand_loaded  = loaded_q[cand_q];
		sts.cand_last    = cand_q == SW'(MERGE_WAYS - 1);
		sts.found        = found_q;
		sts.cand_less    = (a_zero && !b_zero) || (!a_zero && !b_zero && fa < fb);
		sts.cand_greater = (b_zero && !a_zero) || (!a_zero && !b_zero && fa > fb);
		sts.str_end      = a_zero && b_zero;
		sts.idx_last     = idx_q == IW'(KEY_LENGTH - 1);
		sts.key_last     = key_q == KW'(skms_pkg::KEY_COUNT - 1);
		sts.out_free     = !out_valid_q || m_axis_tready;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(skms_pkg::OUT_DATA_W - 4)'(0), 4'(out_num_q)};
	assign m_axis_tuser  = out_found_q;

endmodule

// ===== hdl/stable_kway_merge_selector.sv =====
// a select scans the sources in turn and compares each loaded candidate with the best,
// the bytes walked one at a time through the two read ports of the key store,
// each byte a read and a compare state
// throughput: writes and marks one word per cycle between selects, one select at a time
// reset: arst_n clears the loaded marks, controller and output word at once;
// the key store is not cleared and holds whatever was written
`timescale 1ns / 1ps

module stable_kway_merge_selector #(
	parameter int MERGE_WAYS = 10,
	parameter int KEY_LENGTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// source_number[3:0], key_field[5:4], byte_index[11:6], key_byte[19:12], zero fill
	input  logic [23:0] s_axis_tdata,
	// action[1:0]
	input  logic [1:0]  s_axis_tuser,
	// result words
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// winner_number[3:0], zero fill
	output logic [7:0]  m_axis_tdata,
	// winner_found[0]
	output logic [0:0]  m_axis_tuser
);

	// command and status between controller and datapath
	skms_pkg::cmd_t    cmd;
	skms_pkg::status_t sts;

	// input taken only while the controller is idle; the output register
	// lets new words in while a select result still waits
	assign s_axis_tready = cmd.in_ready;

	skms_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	skms_dpath #(
		.MERGE_WAYS (MERGE_WAYS),
		.KEY_LENGTH (KEY_LENGTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== tb/sv/skms_merge_checker.sv =====
// checker for the stable k-way merge selector: mirrors the head store and the loaded marks,
// picks the expected winner on every select word and compares it with the result words
// depends on skms_pkg for action codes, key count and stream widths
`timescale 1ns / 1ps

module skms_merge_checker #(
	parameter int MERGE_WAYS = 10,
	parameter int KEY_LENGTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	// source_number[3:0], key_field[5:4], byte_index[11:6], key_byte[19:12], zero fill
	input  logic [skms_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// action[1:0]
	input  logic [skms_pkg::IN_USER_W-1:0]  s_axis_tuser,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// winner_number[3:0], zero fill
	input  logic [skms_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// winner_found[0]
	input  logic [skms_pkg::OUT_USER_W-1:0] m_axis_tuser,
	output int                              mismatch_count,
	output int                              winners_pending
);

	typedef struct packed {
		logic [3:0] number;
		logic       found;
	} winner_t;

	logic [7:0]            head_text [MERGE_WAYS][skms_pkg::KEY_COUNT][KEY_LENGTH];
	logic [MERGE_WAYS-1:0] heads_loaded = '0;
	winner_t               winner_queue [$];

	logic [1:0] in_act;
	logic [3:0] in_src;
	logic [1:0] in_key;
	logic [5:0] in_idx;
	logic [7:0] in_byte;
	winner_t    oldest;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		if (c >= skms_pkg::CHAR_UP_A && c <= skms_pkg::CHAR_UP_Z) begin
			return c + (skms_pkg::CHAR_LO_A - skms_pkg::CHAR_UP_A);
		end
		return c;
	endfunction

	// -1, 0 or 1 for one key string of two heads; a string that fills the slot ends there
	function automatic int text_order(input int a, input int b, input int k);
		logic [7:0] ca;
		logic [7:0] cb;
		for (int i = 0; i < KEY_LENGTH; i++) begin
			ca = head_text[a][k][i];
			cb = head_text[b][k][i];
			if (ca == 8'd0 || cb == 8'd0) begin
				if (ca == cb) begin
					return 0;
				end
				return (ca == 8'd0) ? -1 : 1;
			end
			ca = to_lower(ca);
			cb = to_lower(cb);
			if (ca != cb) begin
				return (ca < cb) ? -1 : 1;
			end
		end
		return 0;
	endfunction

	// artist, then album, title and filename
	function automatic int head_order(input int a, input int b);
		int r;
		for (int k = 0; k < skms_pkg::KEY_COUNT; k++) begin
			r = text_order(a, b, k);
			if (r != 0) begin
				return r;
			end
		end
		return 0;
	endfunction

	// lowest source wins ties, as only a strictly smaller head replaces the best
	function automatic winner_t take_smallest_head();
		winner_t w;
		int      best;
		logic    any;
		best = 0;
		any = 1'b0;
		for (int s = 0; s < MERGE_WAYS; s++) begin
			if (heads_loaded[s]) begin
				if (!any) begin
					best = s;
					any = 1'b1;
				end else if (head_order(s, best) < 0) begin
					best = s;
				end
			end
		end
		if (any) begin
			heads_loaded[best] = 1'b0;
		end
		w.number = best[3:0];
		w.found = any;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heads_loaded = '0;
			winner_queue.delete();
			winners_pending = 0;
			mismatch_count = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				in_act = s_axis_tuser;
				in_src = s_axis_tdata[3:0];
				in_key = s_axis_tdata[5:4];
				in_idx = s_axis_tdata[11:6];
				in_byte = s_axis_tdata[19:12];
				if (in_act == skms_pkg::ACT_SELECT) begin
					winner_queue.push_back(take_smallest_head());
				end else if (in_src < MERGE_WAYS) begin
					case (in_act)
						skms_pkg::ACT_WRITE: begin
							if (in_idx < KEY_LENGTH) begin
								head_text[in_src][in_key][in_idx] = in_byte;
							end
						end
						skms_pkg::ACT_LOAD: begin
							heads_loaded[in_src] = 1'b1;
						end
						default: begin
							heads_loaded[in_src] = 1'b0;
						end
					endcase
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (winner_queue.size() == 0) begin
					$error("result word with no select waiting: winner_number %0d winner_found %0d",
						m_axis_tdata[3:0], m_axis_tuser[0]);
					mismatch_count++;
				end else begin
					oldest = winner_queue.pop_front();
					if (m_axis_tdata[3:0] !== oldest.number) begin
						$error("winner_number: expected %0d, actual %0d",
							oldest.number, m_axis_tdata[3:0]);
						mismatch_count++;
					end
					if (m_axis_tuser[0] !== oldest.found) begin
						$error("winner_found: expected %0d, actual %0d",
							oldest.found, m_axis_tuser[0]);
						mismatch_count++;
					end
				end
			end
			winners_pending = winner_queue.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// top of the merge selector testbench: clock, reset, input words and receiver stalls
// depends on skms_pkg, stable_kway_merge_selector and skms_merge_checker
`timescale 1ns / 1ps

module tb_top;

	localparam int MERGE_WAYS   = 10;
	localparam int KEY_LENGTH   = 64;
	localparam int RANDOM_WORDS = 1300;
	localparam int DRAIN_CYCLES = 64;
	localparam logic [7:0] CHAR_LO_Z = 8'h7A;
	// a A b B z Z @ [ ` { from the lowest byte up: letters and the bytes around them
	localparam logic [79:0] TEXT_CHARS =
		{8'h7B, 8'h60, 8'h5B, 8'h40, 8'h5A, 8'h7A, 8'h42, 8'h62, 8'h41, 8'h61};

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [skms_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [skms_pkg::IN_USER_W-1:0]  s_axis_tuser = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [skms_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic [skms_pkg::OUT_USER_W-1:0] m_axis_tuser;
	int                              mismatch_count;
	int                              winners_pending;

	// idle chance per cycle, in percent, for each side
	int sender_idle_pct = 36;
	int receiver_idle_pct = 80;
	int words_sent = 0;

	// what the stimulus knows it has written; only used to keep reads of unwritten bytes away
	logic [7:0] shadow_text [MERGE_WAYS][skms_pkg::KEY_COUNT][KEY_LENGTH];
	bit         shadow_written [MERGE_WAYS][skms_pkg::KEY_COUNT][KEY_LENGTH];
	// set on load, cleared only on exhaust: a popped head still counts as possibly loaded
	bit         maybe_loaded [MERGE_WAYS];

	// key string being built, and the last record's strings for near-duplicate records
	logic [7:0] key_text [KEY_LENGTH];
	int         key_len;
	logic [7:0] last_text [skms_pkg::KEY_COUNT][KEY_LENGTH];
	int         last_len [skms_pkg::KEY_COUNT];

	stable_kway_merge_selector #(
		.MERGE_WAYS(MERGE_WAYS),
		.KEY_LENGTH(KEY_LENGTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	skms_merge_checker #(
		.MERGE_WAYS(MERGE_WAYS),
		.KEY_LENGTH(KEY_LENGTH)
	) merge_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.mismatch_count(mismatch_count),
		.winners_pending(winners_pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// receiver stalls, redrawn every cycle away from the sampling edge
	always @(negedge clk) begin
		m_axis_tready = ($urandom_range(99) >= receiver_idle_pct);
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// true when every key string of the source is written from byte 0 up to its end
	function automatic bit strings_defined(input int s);
		bit ended;
		for (int k = 0; k < skms_pkg::KEY_COUNT; k++) begin
			ended = 1'b0;
			for (int i = 0; i < KEY_LENGTH && !ended; i++) begin
				if (!shadow_written[s][k][i]) begin
					return 1'b0;
				end
				ended = (shadow_text[s][k][i] == 8'd0);
			end
		end
		return 1'b1;
	endfunction

	// one input word: optional idle cycles, then hold until accepted; returns at a falling edge
	task automatic put_word(input logic [1:0] act, input int src, input int key,
		input int idx, input logic [7:0] byt);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tuser = act;
		s_axis_tdata = {4'd0, byt, idx[5:0], key[1:0], src[3:0]};
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		words_sent++;
		if (src < MERGE_WAYS) begin
			case (act)
				skms_pkg::ACT_WRITE: begin
					shadow_text[src][key][idx] = byt;
					shadow_written[src][key][idx] = 1'b1;
				end
				skms_pkg::ACT_LOAD: begin
					maybe_loaded[src] = 1'b1;
				end
				skms_pkg::ACT_EXHAUST: begin
					maybe_loaded[src] = 1'b0;
				end
				default: begin
				end
			endcase
		end
	endtask

	// pause the sender until every select has answered
	task automatic await_winners();
		s_axis_tvalid = 1'b0;
		while (winners_pending != 0) begin
			@(negedge clk);
		end
	endtask

	// key_text into one key slot, with a terminator unless the string fills the slot
	task automatic put_key(input int src, input int key);
		for (int i = 0; i < key_len; i++) begin
			put_word(skms_pkg::ACT_WRITE, src, key, i, key_text[i]);
		end
		if (key_len < KEY_LENGTH) begin
			put_word(skms_pkg::ACT_WRITE, src, key, key_len, 8'd0);
		end
	endtask

	// artist of one character (or empty for zero), other keys empty, then mark loaded
	task automatic tiny_record(input int src, input logic [7:0] c);
		for (int k = 0; k < skms_pkg::KEY_COUNT; k++) begin
			key_len = (k == 0 && c != 8'd0) ? 1 : 0;
			key_text[0] = c;
			put_key(src, k);
		end
		put_word(skms_pkg::ACT_LOAD, src, 0, 0, 8'd0);
	endtask

	task automatic make_text(input int k, input bit twin);
		int         mode;
		logic [7:0] c;
		mode = $urandom_range(31);
		if (twin) begin
			// same string with letters flipped in case at random: equal once folded
			key_len = last_len[k];
			for (int i = 0; i < key_len; i++) begin
				c = last_text[k][i];
				if ((c | 8'h20) >= skms_pkg::CHAR_LO_A && (c | 8'h20) <= CHAR_LO_Z
					&& $urandom_range(1) == 1) begin
					c = c ^ 8'h20;
				end
				key_text[i] = c;
			end
		end else if (mode == 0) begin
			// fills the whole slot, every byte an upper or lower case a
			key_len = KEY_LENGTH;
			for (int i = 0; i < KEY_LENGTH; i++) begin
				key_text[i] = $urandom_range(1) ? skms_pkg::CHAR_LO_A : skms_pkg::CHAR_UP_A;
			end
		end else if (mode < 4) begin
			key_len = $urandom_range(8);
			for (int i = 0; i < key_len; i++) begin
				key_text[i] = 8'($urandom_range(255, 1));
			end
		end else begin
			// short strings from a narrow set, so that ties and shared prefixes are common
			key_len = $urandom_range(3);
			for (int i = 0; i < key_len; i++) begin
				key_text[i] = TEXT_CHARS[8 * ((mode < 12) ? $urandom_range(9)
					: $urandom_range(3)) +: 8];
			end
		end
		last_len[k] = key_len;
		for (int i = 0; i < KEY_LENGTH; i++) begin
			last_text[k][i] = key_text[i];
		end
	endtask

	// refill one source: exhaust it, write all four keys, mark it loaded unless broken off
	task automatic load_record(input int src, input bit twin, input bit skip_load);
		put_word(skms_pkg::ACT_EXHAUST, src, 0, 0, 8'd0);
		for (int k = 0; k < skms_pkg::KEY_COUNT; k++) begin
			make_text(k, twin);
			put_key(src, k);
		end
		if (!skip_load) begin
			put_word(skms_pkg::ACT_LOAD, src, 0, 0, 8'd0);
		end
	endtask

	// any action with any fields, bent only where it could expose an unwritten byte
	task automatic noise_word();
		logic [1:0] act;
		int         src;
		int         key;
		int         idx;
		logic [7:0] byt;
		logic [7:0] kept_byte;
		bit         kept_written;
		act = 2'($urandom_range(3));
		src = $urandom_range(15);
		key = $urandom_range(3);
		idx = $urandom_range(63);
		byt = 8'($urandom_range(255));
		if (src < MERGE_WAYS) begin
			if (act == skms_pkg::ACT_LOAD && !strings_defined(src)) begin
				src = MERGE_WAYS + $urandom_range(15 - MERGE_WAYS);
			end else if (act == skms_pkg::ACT_WRITE && maybe_loaded[src]) begin
				// a zero byte never stretches a string into unwritten bytes
				kept_byte = shadow_text[src][key][idx];
				kept_written = shadow_written[src][key][idx];
				shadow_text[src][key][idx] = byt;
				shadow_written[src][key][idx] = 1'b1;
				if (!strings_defined(src)) begin
					byt = 8'd0;
				end
				shadow_text[src][key][idx] = kept_byte;
				shadow_written[src][key][idx] = kept_written;
			end
		end
		put_word(act, src, key, idx, byt);
	endtask

	initial begin
		int start_count;
		int roll;
		int burst;

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// nothing loaded yet: no winner, number zero
		put_word(skms_pkg::ACT_SELECT, 0, 0, 0, 8'd0);
		// sources past the last way are ignored
		put_word(skms_pkg::ACT_LOAD, 15, 0, 0, 8'd0);
		put_word(skms_pkg::ACT_EXHAUST, 12, 0, 0, 8'd0);
		put_word(skms_pkg::ACT_WRITE, 10, 3, 63, 8'hFF);
		// B and b tie once folded, a sorts first; the lower source wins the tie
		tiny_record(9, skms_pkg::CHAR_UP_A + 8'd1);
		tiny_record(0, skms_pkg::CHAR_LO_A + 8'd1);
		tiny_record(4, skms_pkg::CHAR_LO_A);
		// marking a loaded head again changes nothing
		put_word(skms_pkg::ACT_LOAD, 4, 0, 0, 8'd0);
		repeat (4) put_word(skms_pkg::ACT_SELECT, 0, 0, 0, 8'd0);
		await_winners();

		start_count = words_sent;
		for (int phase = 0; phase < 3; phase++) begin
			// sender mostly busy then receiver mostly busy, last phase with no idling
			sender_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 80 : 0;
			receiver_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 36 : 0;
			while (words_sent < start_count + (phase + 1) * RANDOM_WORDS / 3) begin
				roll = $urandom_range(99);
				if (roll < 45) begin
					// fill: a few records, some near copies of the previous one
					burst = $urandom_range(5, 1);
					repeat (burst) begin
						load_record($urandom_range(MERGE_WAYS - 1),
							$urandom_range(5) == 0, $urandom_range(9) == 0);
					end
				end else if (roll < 85) begin
					// drain: a run of selects with junk in the unused fields
					burst = $urandom_range(6, 1);
					repeat (burst) begin
						put_word(skms_pkg::ACT_SELECT, $urandom_range(15), $urandom_range(3),
							$urandom_range(63), 8'($urandom_range(255)));
					end
				end else begin
					burst = $urandom_range(3, 1);
					repeat (burst) noise_word();
				end
			end
			await_winners();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
